### rtl/throttle_pid_with_brake_override_defines.svh
// ============================================================================
// Assertion macros for the throttle PID block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef THROTTLE_PID_WITH_BRAKE_OVERRIDE_DEFINES_SVH
`define THROTTLE_PID_WITH_BRAKE_OVERRIDE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tpid_pkg.sv
// ============================================================================
// tpid_pkg
// Types, register indexes, command codes and constants of the throttle PID.
// ============================================================================
package tpid_pkg;

	// Datapath widths.
	localparam int ERR_W   = 17;
	localparam int DIFF_W  = 18;
	localparam int INTEG_W = 32;
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = 52;
	localparam int SUM_W   = 64;

	// Configuration register indexes.
	localparam logic [2:0] REG_KP     = 3'd0;
	localparam logic [2:0] REG_KI     = 3'd1;
	localparam logic [2:0] REG_KD     = 3'd2;
	localparam logic [2:0] REG_PERIOD = 3'd3;
	localparam logic [2:0] REG_SPS    = 3'd4;

	// Configuration values after reset.
	localparam logic [15:0] KP_RESET     = 16'd356;
	localparam logic [15:0] KI_RESET     = 16'd1023;
	localparam logic [15:0] KD_RESET     = 16'd0;
	localparam logic [15:0] PERIOD_RESET = 16'd1311;
	localparam logic [9:0]  SPS_RESET    = 10'd50;

	// Integral saturation limits.
	localparam logic [INTEG_W-1:0] INTEG_MAX = 32'h7FFF_FFFF;
	localparam logic [INTEG_W-1:0] INTEG_MIN = 32'h8000_0000;

	// Throttle full scale in 1/256 percent, and the same in accumulator units.
	localparam logic [14:0] THROTTLE_FULL = 15'd25600;
	localparam logic signed [SUM_W-1:0] THROTTLE_FULL_ACC = 64'sd429496729600;

	// Servo angle mapping: 90 + pct * 9 / 10, the divide by ten as a reciprocal.
	localparam logic [7:0]  SERVO_RELEASED = 8'd90;
	localparam logic [6:0]  PCT_MAX        = 7'd100;
	localparam logic [9:0]  SERVO_MUL      = 10'd9;
	localparam logic [25:0] SERVO_RECIP    = 26'd6554;

	// DAC mapping: floor((25600 + t) * 17 / 5632), the divide by 11 as a reciprocal.
	localparam logic [27:0] DAC_RECIP        = 28'd95326;
	localparam logic [7:0]  DAC_IDLE_PRIMARY = 8'd77;

	// Multiplier operand selection.
	typedef logic [2:0] mul_sel_t;
	localparam mul_sel_t MUL_ERR_PERIOD = 3'd0;
	localparam mul_sel_t MUL_ERR_KP     = 3'd1;
	localparam mul_sel_t MUL_KI_INTEG   = 3'd2;
	localparam mul_sel_t MUL_KD_DIFF    = 3'd3;
	localparam mul_sel_t MUL_KDD_SPS    = 3'd4;

	// Accumulator operations.
	typedef logic [1:0] acc_op_t;
	localparam acc_op_t ACC_NONE    = 2'd0;
	localparam acc_op_t ACC_PLAIN   = 2'd1;
	localparam acc_op_t ACC_SHIFT16 = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		logic     classify;
		logic     clear_integ;
		logic     update_integ;
		logic     mul_en;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     clamp;
		logic     out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic brake_active;
		logic err_positive;
	} dp_status_t;

	// Brake command to servo angle.
	function automatic logic [7:0] servo_angle_f(input logic [15:0] brake);
		logic [6:0]  pct;
		logic [9:0]  scaled;
		logic [25:0] prod;
		begin
			pct = 7'd0;
			if (!brake[15] && (brake != 16'd0)) begin
				pct = (brake[14:8] > PCT_MAX) ? PCT_MAX : brake[14:8];
			end
			scaled = {3'b000, pct} * SERVO_MUL;
			prod = {16'd0, scaled} * SERVO_RECIP;
			return SERVO_RELEASED + prod[23:16];
		end
	endfunction

	// Throttle level to the primary DAC code.
	function automatic logic [7:0] dac_primary_f(input logic [14:0] thr);
		logic [15:0] base;
		logic [20:0] scaled;
		logic [27:0] prod;
		begin
			base = {1'b0, THROTTLE_FULL} + {1'b0, thr};
			scaled = {1'b0, base, 4'b0000} + {5'd0, base};
			prod = {17'd0, scaled[19:9]} * DAC_RECIP;
			return prod[27:20];
		end
	endfunction

endpackage

### rtl/throttle_pid_with_brake_override.sv
// ============================================================================
// throttle_pid_with_brake_override
// Speed controller: one-sided PID throttle with a brake override.
// ============================================================================
// Usage: one sample (target_speed, measured_speed, brake_request) is taken per
// input transaction on in_valid/in_ready, and exactly one result transaction
// (throttle_level, brake_echo, servo_angle, two DAC codes) follows on
// out_valid/out_ready. Gains and timing registers are written through
// cfg_write/cfg_index/cfg_data while no sample is in flight.
// Sequencing: a braking sample, or one whose speed error is zero or negative,
// goes from classification straight to the output step; a PID sample runs
// five passes through the single shared 34x18 multiplier plus the
// integral, accumulate and clamp steps. One sample is worked on at a time:
// a new sample is accepted only after the last one has reached the output register.
// The result sits in an output register: while the receiver stalls, the next
// sample can already be accepted and computed, and it waits for the slot.
// Reset clears the integral and previous error and restores the registers'
// default gains, period and rate; no output is valid after reset.
// ============================================================================
`include "throttle_pid_with_brake_override_defines.svh"

module throttle_pid_with_brake_override (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        target_speed,
	input  logic [15:0]        measured_speed,
	input  logic signed [15:0] brake_request,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [14:0]        throttle_level,
	output logic signed [15:0] brake_echo,
	output logic [7:0]         servo_angle,
	output logic [7:0]         dac_code_primary,
	output logic [6:0]         dac_code_secondary
);

	tpid_pkg::dp_cmd_t    cmd;
	tpid_pkg::dp_status_t status;

	// Sequencer.
	tpid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Arithmetic, state and output registers.
	tpid_datapath u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.target_speed       (target_speed),
		.measured_speed     (measured_speed),
		.brake_request      (brake_request),
		.throttle_level     (throttle_level),
		.brake_echo         (brake_echo),
		.servo_angle        (servo_angle),
		.dac_code_primary   (dac_code_primary),
		.dac_code_secondary (dac_code_secondary)
	);

	// The delivered throttle never exceeds full scale.
	`TPID_ASSERT_NOW(a_throttle_range, out_valid,
		throttle_level <= tpid_pkg::THROTTLE_FULL, "throttle above full scale")
	// A braking result carries zero throttle and the idle DAC code.
	`TPID_ASSERT_NOW(a_brake_result, out_valid && !brake_echo[15] && (brake_echo != 16'sd0),
		(throttle_level == 15'd0) && (dac_code_primary == tpid_pkg::DAC_IDLE_PRIMARY),
		"brake result has throttle")

endmodule

### rtl/tpid_datapath.sv
// ============================================================================
// tpid_datapath
// Configuration registers, PID state, shared multiplier, accumulator, clamp
// and output registers of the throttle PID.
// ============================================================================
module tpid_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  tpid_pkg::dp_cmd_t   cmd,
	output tpid_pkg::dp_status_t status,
	input  logic                cfg_write,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic [15:0]         target_speed,
	input  logic [15:0]         measured_speed,
	input  logic signed [15:0]  brake_request,
	output logic [14:0]         throttle_level,
	output logic signed [15:0]  brake_echo,
	output logic [7:0]          servo_angle,
	output logic [7:0]          dac_code_primary,
	output logic [6:0]          dac_code_secondary
);

	// Configuration registers.
	logic [15:0] kp_q;
	logic [15:0] ki_q;
	logic [15:0] kd_q;
	logic [15:0] period_q;
	logic [9:0]  sps_q;

	// Controller state.
	logic [tpid_pkg::INTEG_W-1:0] integral_q;
	logic [tpid_pkg::ERR_W-1:0]   prev_err_q;

	// Working registers of one transaction.
	logic [tpid_pkg::ERR_W-1:0]         err_q;
	logic [15:0]                        brake_q;
	logic [tpid_pkg::DIFF_W-1:0]        diff_q;
	logic signed [tpid_pkg::PROD_W-1:0] prod_q;
	logic signed [tpid_pkg::SUM_W-1:0]  sum_q;
	logic [14:0]                        throttle_q;
	logic [7:0]                         angle_q;

	// Output registers.
	logic [14:0] throttle_out_q;
	logic [15:0] brake_out_q;
	logic [7:0]  angle_out_q;
	logic [7:0]  dac_out_q;

	logic signed [tpid_pkg::MUL_A_W-1:0] mul_a;
	logic signed [tpid_pkg::MUL_B_W-1:0] mul_b;
	logic signed [tpid_pkg::PROD_W-1:0]  mul_p;
	logic [tpid_pkg::MUL_A_W-1:0]        integ_sum;
	logic signed [tpid_pkg::SUM_W-1:0]   prod_ext;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= tpid_pkg::KP_RESET;
			ki_q     <= tpid_pkg::KI_RESET;
			kd_q     <= tpid_pkg::KD_RESET;
			period_q <= tpid_pkg::PERIOD_RESET;
			sps_q    <= tpid_pkg::SPS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tpid_pkg::REG_KP:     kp_q     <= cfg_data;
				tpid_pkg::REG_KI:     ki_q     <= cfg_data;
				tpid_pkg::REG_KD:     kd_q     <= cfg_data;
				tpid_pkg::REG_PERIOD: period_q <= cfg_data;
				tpid_pkg::REG_SPS:    sps_q    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Status toward the controller.
	assign status.brake_active = !brake_q[15] && (brake_q != 16'd0);
	assign status.err_positive = !err_q[tpid_pkg::ERR_W-1] && (err_q != '0);

	// Operand selection for the shared multiplier.
	always_comb begin
		case (cmd.mul_sel)
			tpid_pkg::MUL_ERR_PERIOD: begin
				mul_a = {{17{err_q[16]}}, err_q};
				mul_b = {2'b00, period_q};
			end
			tpid_pkg::MUL_ERR_KP: begin
				mul_a = {{17{err_q[16]}}, err_q};
				mul_b = {{2{kp_q[15]}}, kp_q};
			end
			tpid_pkg::MUL_KI_INTEG: begin
				mul_a = {{2{integral_q[31]}}, integral_q};
				mul_b = {{2{ki_q[15]}}, ki_q};
			end
			tpid_pkg::MUL_KD_DIFF: begin
				mul_a = {{16{diff_q[17]}}, diff_q};
				mul_b = {{2{kd_q[15]}}, kd_q};
			end
			tpid_pkg::MUL_KDD_SPS: begin
				mul_a = prod_q[tpid_pkg::MUL_A_W-1:0];
				mul_b = {8'd0, sps_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Integral plus the new increment, before saturation.
	assign integ_sum = {{2{integral_q[31]}}, integral_q} + prod_q[tpid_pkg::MUL_A_W-1:0];

	assign prod_ext = {{(tpid_pkg::SUM_W - tpid_pkg::PROD_W){prod_q[tpid_pkg::PROD_W-1]}}, prod_q};

	// PID state: the integral saturates at 32 bits; the previous error follows a
	// positive error only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			prev_err_q <= '0;
		end else begin
			if (cmd.clear_integ) begin
				integral_q <= '0;
			end else if (cmd.update_integ) begin
				if ((integ_sum[33:31] == 3'b000) || (integ_sum[33:31] == 3'b111)) begin
					integral_q <= integ_sum[31:0];
				end else if (integ_sum[33]) begin
					integral_q <= tpid_pkg::INTEG_MIN;
				end else begin
					integral_q <= tpid_pkg::INTEG_MAX;
				end
			end
			if (cmd.clamp) begin
				prev_err_q <= err_q;
			end
		end
	end

	// Working registers: capture, classify, multiply, accumulate and clamp.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q   <= {1'b0, target_speed} - {1'b0, measured_speed};
			brake_q <= brake_request;
		end
		if (cmd.classify) begin
			angle_q    <= tpid_pkg::servo_angle_f(brake_q);
			diff_q     <= {err_q[16], err_q} - {prev_err_q[16], prev_err_q};
			throttle_q <= '0;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.classify) begin
			sum_q <= '0;
		end else begin
			case (cmd.acc_op)
				tpid_pkg::ACC_PLAIN:   sum_q <= sum_q + prod_ext;
				tpid_pkg::ACC_SHIFT16: sum_q <= sum_q + {prod_ext[47:0], 16'd0};
				default: ;
			endcase
		end
		if (cmd.clamp) begin
			if (sum_q <= 64'sd0) begin
				throttle_q <= '0;
			end else if (sum_q >= tpid_pkg::THROTTLE_FULL_ACC) begin
				throttle_q <= tpid_pkg::THROTTLE_FULL;
			end else begin
				throttle_q <= sum_q[38:24];
			end
		end
	end

	// Output register, loaded once the receiver has room.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			throttle_out_q <= throttle_q;
			brake_out_q    <= brake_q;
			angle_out_q    <= angle_q;
			dac_out_q      <= tpid_pkg::dac_primary_f(throttle_q);
		end
	end

	assign throttle_level     = throttle_out_q;
	assign brake_echo         = brake_out_q;
	assign servo_angle        = angle_out_q;
	assign dac_code_primary   = dac_out_q;
	assign dac_code_secondary = dac_out_q[7:1];

endmodule

### rtl/tpid_ctrl.sv
// ============================================================================
// tpid_ctrl
// Sequencer of the throttle PID: handshakes and datapath commands.
// ============================================================================
`include "throttle_pid_with_brake_override_defines.svh"

module tpid_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  tpid_pkg::dp_status_t status,
	output tpid_pkg::dp_cmd_t    cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CLASS  = 4'd1;
	localparam logic [3:0] S_INTEG  = 4'd2;
	localparam logic [3:0] S_MUL_I  = 4'd3;
	localparam logic [3:0] S_MUL_D1 = 4'd4;
	localparam logic [3:0] S_MUL_D2 = 4'd5;
	localparam logic [3:0] S_ACC_D  = 4'd6;
	localparam logic [3:0] S_CLAMP  = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_next;
	logic       out_valid_q;

	// Next state and command decode.
	always_comb begin
		cmd        = '0;
		state_next = state_q;
		in_ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = S_CLASS;
				end
			end
			S_CLASS: begin
				cmd.classify = 1'b1;
				if (status.brake_active) begin
					state_next = S_DONE;
				end else if (!status.err_positive) begin
					cmd.clear_integ = 1'b1;
					state_next      = S_DONE;
				end else begin
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = tpid_pkg::MUL_ERR_PERIOD;
					state_next  = S_INTEG;
				end
			end
			S_INTEG: begin
				cmd.update_integ = 1'b1;
				cmd.mul_en       = 1'b1;
				cmd.mul_sel      = tpid_pkg::MUL_ERR_KP;
				state_next       = S_MUL_I;
			end
			S_MUL_I: begin
				cmd.acc_op  = tpid_pkg::ACC_SHIFT16;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tpid_pkg::MUL_KI_INTEG;
				state_next  = S_MUL_D1;
			end
			S_MUL_D1: begin
				cmd.acc_op  = tpid_pkg::ACC_PLAIN;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tpid_pkg::MUL_KD_DIFF;
				state_next  = S_MUL_D2;
			end
			S_MUL_D2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tpid_pkg::MUL_KDD_SPS;
				state_next  = S_ACC_D;
			end
			S_ACC_D: begin
				cmd.acc_op = tpid_pkg::ACC_SHIFT16;
				state_next = S_CLAMP;
			end
			S_CLAMP: begin
				cmd.clamp  = 1'b1;
				state_next = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_next   = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// An accepted transaction is classified in the following cycle.
	`TPID_ASSERT_NEXT(a_accept_to_class, in_valid && in_ready, state_q == S_CLASS, "accept lost")
	// A braking sample skips the PID sequence.
	`TPID_ASSERT_NEXT(a_brake_skips_pid, (state_q == S_CLASS) && status.brake_active, state_q == S_DONE, "brake ran PID")
	// A finished result waits while the output slot is still taken.
	`TPID_ASSERT_NEXT(a_done_waits, (state_q == S_DONE) && out_valid_q && !out_ready, (state_q == S_DONE) && out_valid_q, "result overwrote output")

endmodule
